@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion wrappers, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge, disabled while rst is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication form: antecedent on one edge, consequent on the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/uart_trx_pkg.sv @@
// ----------------------------------------------------------------------------
// uart_trx_pkg
// Shared types and constants of the tick-driven 8N1 UART transceiver.
// ----------------------------------------------------------------------------
package uart_trx_pkg;

  typedef logic [15:0] period_t;
  typedef logic [10:0] frame_t;
  typedef logic [9:0]  rx_shift_t;

  localparam period_t     PERIOD_RESET   = 16'd1666;
  localparam int          FIFO_DEPTH_DEF = 4;
  // start 0, data, stop 1, end mark 1
  localparam logic [1:0]  FRAME_TOP      = 2'b11;
  // last of ten receive samples (bit counter value before it)
  localparam logic [3:0]  RX_LAST        = 4'd9;
  // four equal samples flip the filtered level
  localparam logic [1:0]  FILTER_LAST    = 2'd3;

endpackage

@@ sv/timer_driven_uart_transceiver_top.sv @@
// ----------------------------------------------------------------------------
// timer_driven_uart_transceiver_top
// An accepted tick's result beat is registered and appears in the next cycle.
// Throughput: one tick per cycle; in_ready drops only while a result is held
// by out_ready low. The receive FIFO is a RAM read in the accept cycle.
// Reset (rst, synchronous): counter, transmitter, receiver and FIFO pointers
// clear, bit_period returns to 1666; FIFO contents are left as they are.
// ----------------------------------------------------------------------------
module timer_driven_uart_transceiver_top #(
  parameter int FIFO_DEPTH = uart_trx_pkg::FIFO_DEPTH_DEF,
  parameter int CW         = $clog2(FIFO_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  // configuration: bit_period
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data,
  // tick input channel
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          rx_line,
  input  logic          send_request,
  input  logic [7:0]    send_byte,
  input  logic          read_request,
  // result channel
  output logic          out_valid,
  input  logic          out_ready,
  output logic          tx_line,
  output logic          tx_busy,
  output logic          send_accepted,
  output logic          read_valid,
  output logic [7:0]    read_data,
  output logic [CW-1:0] fifo_count,
  output logic          rx_dropped
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int SW = CW + 1;
  localparam logic [AW:0]   DEPTH_H = (AW + 1)'(FIFO_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(FIFO_DEPTH);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  uart_trx_pkg::period_t   bit_period;
  uart_trx_pkg::period_t   tick_count;
  uart_trx_pkg::frame_t    tx_frame;
  logic                    tx_level;
  logic                    rx_active;
  uart_trx_pkg::period_t   rx_sample_point;
  uart_trx_pkg::rx_shift_t rx_shift;
  logic [3:0]              rx_bit_count;
  logic                    rx_filtered;
  logic [1:0]              rx_filter_run;
  logic [AW-1:0]           fifo_head;
  logic [CW-1:0]           fifo_fill;

  // next values
  uart_trx_pkg::period_t   tick_count_next;
  uart_trx_pkg::frame_t    tx_frame_next;
  logic                    tx_level_next;
  logic                    rx_active_next;
  uart_trx_pkg::period_t   rx_sample_point_next;
  uart_trx_pkg::rx_shift_t rx_shift_next;
  logic [3:0]              rx_bit_count_next;
  logic                    rx_filtered_next;
  logic [1:0]              rx_filter_run_next;
  logic [AW-1:0]           fifo_head_next;
  logic [CW-1:0]           fifo_fill_next;

  logic in_fire;
  logic cfg_fire;

  // One result register: a new tick enters whenever the slot is empty or
  // its beat leaves in the same cycle.
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // --------------------------------------------------------------------------
  // Tick counter: 0..bit_period, wrap marks a bit time.
  // --------------------------------------------------------------------------
  logic wrap;
  assign wrap            = (tick_count >= bit_period);
  assign tick_count_next = wrap ? '0 : tick_count + 16'd1;

  // --------------------------------------------------------------------------
  // Transmitter: shift one frame bit out per wrap, then load a new byte
  // if the frame is empty.
  // --------------------------------------------------------------------------
  uart_trx_pkg::frame_t tx_frame_shifted;
  logic                 send_ok;

  always_comb begin
    tx_frame_shifted = tx_frame;
    tx_level_next    = tx_level;
    if (wrap && (tx_frame != '0)) begin
      tx_level_next    = tx_frame[0];
      tx_frame_shifted = {1'b0, tx_frame[10:1]};
    end
  end

  assign send_ok       = send_request && (tx_frame_shifted == '0);
  assign tx_frame_next = send_ok ? {uart_trx_pkg::FRAME_TOP, send_byte, 1'b0}
                                 : tx_frame_shifted;

  // --------------------------------------------------------------------------
  // Glitch filter: level follows the raw line after four differing samples.
  // --------------------------------------------------------------------------
  logic falling;

  always_comb begin
    rx_filtered_next   = rx_filtered;
    rx_filter_run_next = rx_filter_run;
    falling            = 1'b0;
    priority if (rx_line == rx_filtered) begin
      rx_filter_run_next = '0;
    end else if (rx_filter_run == uart_trx_pkg::FILTER_LAST) begin
      falling            = rx_filtered;
      rx_filtered_next   = rx_line;
      rx_filter_run_next = '0;
    end else begin
      rx_filter_run_next = rx_filter_run + 2'd1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: sample point half a bit after the start edge (mod bit_period),
  // then ten raw samples, one per counter match.
  // --------------------------------------------------------------------------
  logic [16:0]             sp_sum;
  logic [16:0]             sp_wrap;
  uart_trx_pkg::period_t   sp_start;
  uart_trx_pkg::rx_shift_t rx_data;
  logic                    have_byte;
  logic [7:0]              new_byte;

  assign sp_sum   = {1'b0, tick_count_next} + {2'b00, bit_period[15:1]};
  assign sp_wrap  = sp_sum - {1'b0, bit_period};
  assign sp_start = (sp_sum >= {1'b0, bit_period}) ? sp_wrap[15:0] : sp_sum[15:0];
  assign rx_data  = {rx_line, rx_shift[9:1]};
  assign new_byte = rx_data[8:1];

  always_comb begin
    rx_active_next       = rx_active;
    rx_sample_point_next = rx_sample_point;
    rx_shift_next        = rx_shift;
    rx_bit_count_next    = rx_bit_count;
    have_byte            = 1'b0;
    if (rx_active) begin
      if (tick_count_next == rx_sample_point) begin
        if (rx_bit_count >= uart_trx_pkg::RX_LAST) begin
          // frame complete: keep only good start/stop framing
          have_byte      = !rx_data[0] && rx_data[9];
          rx_active_next = 1'b0;
        end else begin
          rx_bit_count_next = rx_bit_count + 4'd1;
          rx_shift_next     = rx_data;
        end
      end
    end else if (falling) begin
      rx_sample_point_next = sp_start;
      rx_active_next       = 1'b1;
      rx_shift_next        = '0;
      rx_bit_count_next    = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Receive FIFO: pop first, then push.
  // --------------------------------------------------------------------------
  logic          pop;
  logic          push;
  logic          drop;
  logic [AW:0]   head_inc;
  logic [CW-1:0] fill_popped;
  logic [SW-1:0] wsum;
  logic [SW-1:0] wsum_wrap;
  logic [AW-1:0] waddr;
  logic [7:0]    ram_q;

  assign pop         = read_request && (fifo_fill != '0);
  assign head_inc    = {1'b0, fifo_head} + (AW + 1)'(1);
  assign fill_popped = fifo_fill - CW'(pop);
  assign push        = have_byte && (fill_popped < DEPTH_C);
  assign drop        = have_byte && !push;

  // head + fill is unchanged by a pop, so the old pair gives the tail
  assign wsum      = SW'(fifo_head) + SW'(fifo_fill);
  assign wsum_wrap = wsum - DEPTH_S;
  assign waddr     = (wsum >= DEPTH_S) ? wsum_wrap[AW-1:0] : wsum[AW-1:0];

  always_comb begin
    fifo_head_next = fifo_head;
    if (pop) begin
      fifo_head_next = (head_inc >= DEPTH_H) ? '0 : head_inc[AW-1:0];
    end
  end
  assign fifo_fill_next = fill_popped + CW'(push);

  // read-first RAM: a pop and a push to the same entry return the old byte
  uart_trx_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_fire && push),
    .waddr (waddr),
    .wdata (new_byte),
    .re    (in_fire && pop),
    .raddr (fifo_head),
    .rdata (ram_q)
  );

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= uart_trx_pkg::PERIOD_RESET;
    end else if (cfg_fire) begin
      bit_period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count      <= '0;
      tx_frame        <= '0;
      tx_level        <= 1'b1;
      rx_active       <= 1'b0;
      rx_sample_point <= '0;
      rx_shift        <= '0;
      rx_bit_count    <= '0;
      rx_filtered     <= 1'b1;
      rx_filter_run   <= '0;
      fifo_head       <= '0;
      fifo_fill       <= '0;
    end else if (in_fire) begin
      tick_count      <= tick_count_next;
      tx_frame        <= tx_frame_next;
      tx_level        <= tx_level_next;
      rx_active       <= rx_active_next;
      rx_sample_point <= rx_sample_point_next;
      rx_shift        <= rx_shift_next;
      rx_bit_count    <= rx_bit_count_next;
      rx_filtered     <= rx_filtered_next;
      rx_filter_run   <= rx_filter_run_next;
      fifo_head       <= fifo_head_next;
      fifo_fill       <= fifo_fill_next;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tx_line       <= tx_level_next;
      tx_busy       <= (tx_frame_next != '0);
      send_accepted <= send_ok;
      read_valid    <= pop;
      fifo_count    <= fifo_fill_next;
      rx_dropped    <= drop;
    end
  end

  // popped byte comes straight from the RAM output register
  assign read_data = read_valid ? ram_q : 8'd0;

endmodule

@@ sv/uart_trx_ram.sv @@
// ----------------------------------------------------------------------------
// uart_trx_ram
// Generic single-write, single-read RAM, registered read-first output.
// ----------------------------------------------------------------------------
module uart_trx_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 4,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/uart_trx_checker.sv @@
// ----------------------------------------------------------------------------
// uart_trx_checker
// Port-level checks on the UART transceiver result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uart_trx_checker #(
  parameter int FIFO_DEPTH = uart_trx_pkg::FIFO_DEPTH_DEF,
  parameter int CW         = $clog2(FIFO_DEPTH + 1)
) (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input logic          tx_line,
  input logic          tx_busy,
  input logic          read_valid,
  input logic [7:0]    read_data,
  input logic [CW-1:0] fifo_count,
  input logic          rx_dropped
);

  localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);

  // stalled beat holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(read_data) && $stable(fifo_count) && $stable(tx_line),
    "result beat changed while stalled")

  `ASSERT_CLK(a_fill_range, clk, rst, !out_valid || (fifo_count <= DEPTH_C),
    "fifo_count beyond depth")

  `ASSERT_CLK(a_rdata_zero, clk, rst, !out_valid || read_valid || (read_data == 8'd0),
    "read_data nonzero without read_valid")

  `ASSERT_CLK(a_drop_full, clk, rst, !out_valid || !rx_dropped || (fifo_count == DEPTH_C),
    "byte dropped while FIFO had room")

  // idle transmitter always ends on a high stop/end-mark level
  `ASSERT_CLK(a_idle_high, clk, rst, !out_valid || tx_busy || tx_line,
    "tx_line low while transmitter idle")

endmodule

bind timer_driven_uart_transceiver_top uart_trx_checker #(
  .FIFO_DEPTH (FIFO_DEPTH)
) u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .tx_line       (tx_line),
  .tx_busy       (tx_busy),
  .read_valid    (read_valid),
  .read_data     (read_data),
  .fifo_count    (fifo_count),
  .rx_dropped    (rx_dropped)
);

@@ dv/tb_timer_driven_uart_transceiver_top.sv @@
// ----------------------------------------------------------------------------
// tb_timer_driven_uart_transceiver_top
// Tick-level testbench of the 8N1 UART transceiver. Every accepted tick beat
// runs through a cycle-exact predictor of the tick counter, transmitter,
// filtered receiver and receive FIFO. Each result beat is checked field by
// field against the oldest predicted result. Stimulus covers period extremes,
// refused sends, empty reads, glitches, good and broken serial frames and FIFO
// overflow. Random idle and stall bursts are applied on both channels.
// ----------------------------------------------------------------------------
module tb_timer_driven_uart_transceiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  // one result beat, in port order
  typedef struct packed {
    logic       tx_line;
    logic       tx_busy;
    logic       send_accepted;
    logic       read_valid;
    logic [7:0] read_data;
    logic [2:0] fifo_count;
    logic       rx_dropped;
  } tick_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        rx_line;
  logic        send_request;
  logic [7:0]  send_byte;
  logic        read_request;
  logic        out_valid;
  logic        out_ready;
  logic        tx_line;
  logic        tx_busy;
  logic        send_accepted;
  logic        read_valid;
  logic [7:0]  read_data;
  logic [2:0]  fifo_count;
  logic        rx_dropped;

  timer_driven_uart_transceiver_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_line      (rx_line),
    .send_request (send_request),
    .send_byte    (send_byte),
    .read_request (read_request),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tx_line      (tx_line),
    .tx_busy      (tx_busy),
    .send_accepted(send_accepted),
    .read_valid   (read_valid),
    .read_data    (read_data),
    .fifo_count   (fifo_count),
    .rx_dropped   (rx_dropped)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of everything the block keeps
  // --------------------------------------------------------------------------
  uart_trx_pkg::period_t   pred_period;
  logic [15:0]             pred_tick;
  uart_trx_pkg::frame_t    pred_frame;
  logic                    pred_tx_level;
  logic                    pred_rx_active;
  logic [15:0]             pred_sample_pt;
  uart_trx_pkg::rx_shift_t pred_rx_shift;
  logic [3:0]              pred_rx_bits;
  logic                    pred_rx_filt;
  logic [1:0]              pred_filt_run;
  logic [7:0]              pred_store [uart_trx_pkg::FIFO_DEPTH_DEF];
  logic [1:0]              pred_head;
  logic [2:0]              pred_fill;

  tick_result_t tick_results_due[$];  // predicted beats not yet seen
  int errors;
  int ticks_accepted;
  bit idle_on;                        // random idle/stall bursts enabled
  int send_pct;                       // chance of a send request per tick
  int read_pct;                       // chance of a read request per tick

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns mismatch on %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic void reset_prediction();
    pred_period    = uart_trx_pkg::PERIOD_RESET;
    pred_tick      = '0;
    pred_frame     = '0;
    pred_tx_level  = 1'b1;
    pred_rx_active = 1'b0;
    pred_sample_pt = '0;
    pred_rx_shift  = '0;
    pred_rx_bits   = '0;
    pred_rx_filt   = 1'b1;
    pred_filt_run  = '0;
    foreach (pred_store[i]) pred_store[i] = '0;
    pred_head      = '0;
    pred_fill      = '0;
  endfunction

  // Advance the predicted block by one tick and return that tick's result.
  function automatic tick_result_t uart_tick_predict(logic line, logic sreq,
                                                     logic [7:0] sbyte, logic rreq);
    tick_result_t            r;
    logic                    wrap;
    logic                    falling;
    logic                    have_byte;
    logic [7:0]              new_byte;
    uart_trx_pkg::rx_shift_t shifted;
    logic [16:0]             sp;
    logic [1:0]              wr_idx;
    r         = '0;
    wrap      = 1'b0;
    falling   = 1'b0;
    have_byte = 1'b0;
    new_byte  = '0;

    // tick counter: 0..period, wrap marks one bit time
    if (pred_tick >= pred_period) begin
      pred_tick = '0;
      wrap      = 1'b1;
    end else begin
      pred_tick = pred_tick + 16'd1;
    end

    // transmitter: shift first, then a send may load an empty frame
    if (wrap && pred_frame != '0) begin
      pred_tx_level = pred_frame[0];
      pred_frame    = pred_frame >> 1;
    end
    if (sreq && pred_frame == '0) begin
      pred_frame      = {uart_trx_pkg::FRAME_TOP, sbyte, 1'b0};
      r.send_accepted = 1'b1;
    end

    // glitch filter: four differing samples flip the level
    if (line == pred_rx_filt) begin
      pred_filt_run = '0;
    end else if (pred_filt_run == uart_trx_pkg::FILTER_LAST) begin
      falling       = pred_rx_filt && !line;
      pred_rx_filt  = line;
      pred_filt_run = '0;
    end else begin
      pred_filt_run = pred_filt_run + 2'd1;
    end

    // receiver: raw line sampled at the sample point, ten bits per frame
    if (pred_rx_active) begin
      if (pred_tick == pred_sample_pt) begin
        shifted = {line, pred_rx_shift[9:1]};
        if (pred_rx_bits >= uart_trx_pkg::RX_LAST) begin
          if (!shifted[0] && shifted[9]) begin
            have_byte = 1'b1;
            new_byte  = shifted[8:1];
          end
          pred_rx_active = 1'b0;
        end else begin
          pred_rx_bits  = pred_rx_bits + 4'd1;
          pred_rx_shift = shifted;
        end
      end
    end else if (falling) begin
      // half a bit later, reduced once by the period
      sp = {1'b0, pred_tick} + {2'b0, pred_period[15:1]};
      if (sp >= {1'b0, pred_period}) sp = sp - {1'b0, pred_period};
      pred_sample_pt = sp[15:0];
      pred_rx_active = 1'b1;
      pred_rx_shift  = '0;
      pred_rx_bits   = '0;
    end

    // FIFO: pop before push
    if (rreq && pred_fill != '0) begin
      r.read_valid = 1'b1;
      r.read_data  = pred_store[pred_head];
      pred_head    = pred_head + 2'd1;
      pred_fill    = pred_fill - 3'd1;
    end
    if (have_byte) begin
      if (pred_fill < uart_trx_pkg::FIFO_DEPTH_DEF) begin
        wr_idx             = pred_head + pred_fill[1:0];
        pred_store[wr_idx] = new_byte;
        pred_fill          = pred_fill + 3'd1;
      end else begin
        r.rx_dropped = 1'b1;
      end
    end

    r.tx_line    = pred_tx_level;
    r.tx_busy    = (pred_frame != '0);
    r.fifo_count = pred_fill;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A slow correct run finishes far inside this watchdog time.
  initial begin
    #2ms;
    $display("FAIL timer_driven_uart_transceiver_top");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result checker: sampled at the rising edge, oldest prediction first
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    tick_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (tick_results_due.size() == 0) begin
        report_mismatch("result beat with nothing predicted", 1, 0);
      end else begin
        want = tick_results_due.pop_front();
        if (tx_line !== want.tx_line)
          report_mismatch("tx_line", tx_line, want.tx_line);
        if (tx_busy !== want.tx_busy)
          report_mismatch("tx_busy", tx_busy, want.tx_busy);
        if (send_accepted !== want.send_accepted)
          report_mismatch("send_accepted", send_accepted, want.send_accepted);
        if (read_valid !== want.read_valid)
          report_mismatch("read_valid", read_valid, want.read_valid);
        if (read_data !== want.read_data)
          report_mismatch("read_data", read_data, want.read_data);
        if (fifo_count !== want.fifo_count)
          report_mismatch("fifo_count", fifo_count, want.fifo_count);
        if (rx_dropped !== want.rx_dropped)
          report_mismatch("rx_dropped", rx_dropped, want.rx_dropped);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result-side backpressure: random stall bursts, driven at negedge
  // --------------------------------------------------------------------------
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
        @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // One tick beat. Payload changes only at a negedge; valid stays high
  // straight into the next beat unless an idle burst is drawn.
  task automatic send_tick(input logic line, input logic sreq,
                           input logic [7:0] sbyte, input logic rreq);
    int gap;
    gap = 0;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    rx_line      = line;
    send_request = sreq;
    send_byte    = sbyte;
    read_request = rreq;
    do @(posedge clk); while (in_ready !== 1'b1);
    tick_results_due.push_back(uart_tick_predict(line, sreq, sbyte, rreq));
    ticks_accepted++;
  endtask

  // Tick with the given rx level and random send/read traffic.
  task automatic tick_rand(input logic line);
    send_tick(line, $urandom_range(0, 99) < send_pct, 8'($urandom_range(0, 255)),
              $urandom_range(0, 99) < read_pct);
  endtask

  // Stop sending and wait until every predicted beat is back, then let
  // the result register empty. Bounded; a leftover shows up at the end.
  task automatic wait_drained();
    int guard;
    @(negedge clk);
    in_valid = 1'b0;
    for (guard = 0; guard < 5000 && tick_results_due.size() != 0; guard++)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write, only with the block idle.
  task automatic write_period(input uart_trx_pkg::period_t value);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    pred_period = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic rx_idle(input int n);
    repeat (n) tick_rand(1'b1);
  endtask

  // Serial frame on rx_line, LSB first, bit_len ticks per bit.
  task automatic drive_rx_frame(input logic [7:0] data, input int bit_len,
                                input logic start_bit, input logic stop_bit);
    logic [9:0] bits;
    bits = {stop_bit, data, start_bit};
    for (int i = 0; i < 10; i++)
      repeat (bit_len) tick_rand(bits[i]);
  endtask

  // Mostly good frames, some broken ones, glitches and noise.
  task automatic random_rx_segment(input int bit_len);
    int kind;
    logic [7:0] b;
    kind = $urandom_range(0, 19);
    b    = 8'($urandom_range(0, 255));
    if (kind < 14)
      drive_rx_frame(b, bit_len, 1'b0, 1'b1);
    else if (kind < 16)
      drive_rx_frame(b, bit_len, 1'b0, 1'b0);               // stop bit low
    else if (kind < 17)
      drive_rx_frame(b, $urandom_range(0, 1) ? bit_len + 1 : bit_len - 1, 1'b0, 1'b1);
    else if (kind < 19)
      repeat ($urandom_range(1, 3)) tick_rand(1'b0);        // filtered out
    else
      repeat ($urandom_range(8, 30)) tick_rand(1'($urandom_range(0, 1)));
    rx_idle($urandom_range(4, 2 * bit_len));
  endtask

  task automatic run_rx_traffic(input int quota, input int bit_len);
    int stop_at;
    stop_at = ticks_accepted + quota;
    while (ticks_accepted < stop_at) random_rx_segment(bit_len);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset period: empty read, accepted send, refused send while busy, glitch.
  task automatic test_reset_state();
    send_tick(1'b1, 1'b0, 8'h00, 1'b1);
    send_tick(1'b1, 1'b1, 8'hFF, 1'b0);
    send_tick(1'b1, 1'b1, 8'h00, 1'b0);
    send_tick(1'b0, 1'b0, 8'h00, 1'b0);
    send_tick(1'b1, 1'b0, 8'h00, 1'b1);
  endtask

  // Period 0 and 1 (below range), 65535 and 2.
  task automatic test_period_extremes();
    logic [3:0] i;
    write_period(16'd0);
    // wraps every tick: the reset-time frame drains, then sends reload
    for (i = 0; i < 12; i++)
      send_tick(1'b1, 1'b1, i[0] ? 8'hA5 : 8'h5A, i[1]);
    write_period(16'd1);
    // three low samples only: no edge gets through the filter
    for (i = 0; i < 6; i++)
      send_tick(i < 3 ? 1'b0 : 1'b1, 1'b1, 8'hFF, 1'b1);
    write_period(16'hFFFF);
    repeat (3) send_tick(1'b1, 1'b1, 8'h00, 1'b0);
    write_period(16'd2);
    repeat (3) send_tick(1'b1, 1'b0, 8'h00, 1'b1);
  endtask

  // Start a reception, drop the period under the sample point, then restore
  // it so the frame can finish.
  task automatic test_period_lowered_midframe();
    send_pct = 10;
    read_pct = 10;
    write_period(16'd10);
    rx_idle(6);
    repeat (6) tick_rand(1'b0);
    write_period(16'd2);
    repeat (8) tick_rand(1'b0);
    write_period(16'd10);
    rx_idle(115);
  endtask

  // Random frames at a random bit rate with light reading.
  task automatic test_frames_with_reads();
    uart_trx_pkg::period_t bp;
    send_pct = 25;
    read_pct = 10;
    bp = 16'($urandom_range(7, 9));
    write_period(bp);
    run_rx_traffic(20, int'(bp) + 1);
  endtask

  // Good frames with no reads overrun the FIFO, then reads drain it.
  task automatic test_fifo_overflow();
    write_period(16'd7);
    send_pct = 20;
    read_pct = 0;
    repeat (5) begin
      drive_rx_frame(8'($urandom_range(0, 255)), 8, 1'b0, 1'b1);
      rx_idle(2);
    end
    read_pct = 70;
    rx_idle(12);
  endtask

  // Last part: no idle and no stalls, one beat per cycle.
  task automatic test_back_to_back();
    wait_drained();
    idle_on  = 1'b0;
    send_pct = 40;
    read_pct = 30;
    write_period(16'd7);
    run_rx_traffic(40, 8);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    errors         = 0;
    ticks_accepted = 0;
    idle_on        = 1'b1;
    send_pct       = 0;
    read_pct       = 0;
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    rx_line        = 1'b1;
    send_request   = 1'b0;
    send_byte      = '0;
    read_request   = 1'b0;
    reset_prediction();

    // single synchronous reset at the start
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_period_extremes();
    test_period_lowered_midframe();
    test_frames_with_reads();
    test_fifo_overflow();
    test_back_to_back();

    wait_drained();
    if (tick_results_due.size() != 0)
      report_mismatch("predicted beats never returned", tick_results_due.size(), 0);
    if (errors == 0) begin
      $display("PASS timer_driven_uart_transceiver_top");
    end else begin
      $display("FAIL timer_driven_uart_transceiver_top");
    end
    $finish;
  end

endmodule
